// ===== design/gbce_pkg.sv =====
// Shared constants and register index codes for the clamped-edge Gaussian blur.
`timescale 1ns / 1ps
`default_nettype none
package gbce_pkg;
  localparam int MAX_RADIUS = 3;
  localparam int MAX_WIDTH  = 1024;
  localparam int ROWS_MAX   = 4096;
  localparam int SLOT_ROWS  = 2 * MAX_RADIUS + 2;
  localparam int SLOT_W     = $clog2(SLOT_ROWS);
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(ROWS_MAX);
  localparam int ADDR_W     = SLOT_W + COL_W;
  localparam int MEM_DEPTH  = SLOT_ROWS * MAX_WIDTH;
  localparam int TAP_W      = $clog2(2 * MAX_RADIUS + 1);
  localparam int ACC_W      = 48;

  localparam logic [2:0] REG_RADIUS = 3'd0;
  localparam logic [2:0] REG_COEF0  = 3'd1;
  localparam logic [2:0] REG_COEF1  = 3'd2;
  localparam logic [2:0] REG_COEF2  = 3'd3;
  localparam logic [2:0] REG_COEF3  = 3'd4;
  localparam logic [2:0] REG_WIDTH  = 3'd5;
  localparam logic [2:0] REG_HEIGHT = 3'd6;

  localparam logic REQ_PUSH  = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;
endpackage
`default_nettype wire

// ===== design/gaussian_blur_clamp_edge_top.sv =====
// Top level: line store, window sequencer, multiply-accumulate and output register.
//
//  channel | beat fields                              | handshake
//  in      | tuser: req_type; tdata: blue,green,red   | in_tvalid / in_tready
//  out     | tlast: frame_end; tdata: blue,green,red  | out_tvalid / out_tready
//  cfg     | cfg_addr index, cfg_wdata value          | cfg_we, no wait
//
// A beat that causes no result goes from idle to evaluate and back; one that emits
// a pixel then runs the window, one line store read per window tap, and finishes.
// Reset is synchronous, active low, and clears counters, control and configuration only.
// The result waits in the output register; a new input beat is taken while
// it waits, and a further result stalls until the register is free.
`timescale 1ns / 1ps
`default_nettype none
module gaussian_blur_clamp_edge_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // [7:0] blue_in, [15:8] green_in, [23:16] red_in
  input  wire logic        in_tuser,   // req_type
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [7:0] blue_out, [15:8] green_out, [23:16] red_out
  output logic             out_tlast,  // frame_end
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [15:0] cfg_wdata
);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EVAL = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  localparam int CW = gbce_pkg::COL_W;
  localparam int RW = gbce_pkg::ROW_W;
  localparam int SW = gbce_pkg::SLOT_W;
  localparam int TW = gbce_pkg::TAP_W;
  localparam int AW = gbce_pkg::ACC_W;

  // configuration
  logic [1:0]  radius_r;
  logic [15:0] coef0_r, coef1_r, coef2_r, coef3_r;
  logic [10:0] width_r;
  logic [12:0] height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= 2'd1;
      coef0_r  <= 16'd32768;
      coef1_r  <= 16'd16384;
      coef2_r  <= 16'd0;
      coef3_r  <= 16'd0;
      width_r  <= 11'd1024;
      height_r <= 13'd768;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        gbce_pkg::REG_RADIUS: radius_r <= cfg_wdata[1:0];
        gbce_pkg::REG_COEF0:  coef0_r  <= cfg_wdata;
        gbce_pkg::REG_COEF1:  coef1_r  <= cfg_wdata;
        gbce_pkg::REG_COEF2:  coef2_r  <= cfg_wdata;
        gbce_pkg::REG_COEF3:  coef3_r  <= cfg_wdata;
        gbce_pkg::REG_WIDTH:  width_r  <= cfg_wdata[10:0];
        gbce_pkg::REG_HEIGHT: height_r <= cfg_wdata[12:0];
        default: ;
      endcase
    end
  end

  logic [10:0] w_eff;
  logic [12:0] h_eff;
  logic [1:0]  r_eff;
  always_comb begin
    if (width_r == 11'd0) w_eff = 11'd1;
    else if (width_r > 11'(gbce_pkg::MAX_WIDTH)) w_eff = 11'(gbce_pkg::MAX_WIDTH);
    else w_eff = width_r;
    if (height_r == 13'd0) h_eff = 13'd1;
    else if (height_r > 13'(gbce_pkg::ROWS_MAX)) h_eff = 13'(gbce_pkg::ROWS_MAX);
    else h_eff = height_r;
    r_eff = radius_r;
  end

  // control state
  logic [1:0]    state_r, state_nxt;
  logic          req_r;
  logic [CW-1:0] in_col_r, out_col_r;
  logic [RW-1:0] in_row_r, out_row_r;
  logic [SW-1:0] in_slot_r, out_slot_r;
  logic [11:0]   pending_r;
  logic [TW-1:0] ti_r, tj_r;
  logic          issue_r, s1_v_r, s2_v_r;
  logic          out_valid_r;

  // payload
  logic [31:0]   s1_wt_r;
  logic [23:0]   rd_data_r;
  logic [39:0]   p0_r, p1_r, p2_r;
  logic [AW-1:0] acc0_r, acc1_r, acc2_r;
  logic [23:0]   out_data_r;
  logic          out_last_r;

  logic accept;
  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  // emit decision
  logic [12:0] lag;
  logic [23:0] total, idx, remaining;
  logic        emit_ok;
  always_comb begin
    lag       = 13'(r_eff) * 13'(w_eff) + 13'(r_eff);
    total     = 24'(h_eff) * 24'(w_eff);
    idx       = 24'(out_row_r) * 24'(w_eff) + 24'(out_col_r);
    remaining = (idx < total) ? (total - idx) : 24'd1;
    if (req_r == gbce_pkg::REQ_PUSH)
      emit_ok = 13'(pending_r) > lag;
    else
      emit_ok = (pending_r != 12'd0) &&
                ((13'(pending_r) > lag) || (24'(pending_r) >= remaining));
  end

  // window tap address
  logic [TW-1:0] span, ai, aj;
  logic signed [RW+2:0] yy_raw, yy_cl, dy;
  logic signed [CW+2:0] xx_raw, xx_cl;
  logic [SW-1:0] rd_slot;
  logic [gbce_pkg::ADDR_W-1:0] raddr, waddr;
  logic [15:0] ca, cb;
  logic tap_last;
  always_comb begin
    span   = TW'({r_eff, 1'b0});
    ai     = (ti_r >= TW'(r_eff)) ? ti_r - TW'(r_eff) : TW'(r_eff) - ti_r;
    aj     = (tj_r >= TW'(r_eff)) ? tj_r - TW'(r_eff) : TW'(r_eff) - tj_r;
    yy_raw = $signed({3'b0, out_row_r}) + $signed({{(RW + 3 - TW){1'b0}}, ti_r})
             - $signed({{(RW + 1){1'b0}}, r_eff});
    if (yy_raw < 0) yy_cl = '0;
    else if (yy_raw > $signed({2'b0, h_eff - 13'd1})) yy_cl = $signed({2'b0, h_eff - 13'd1});
    else yy_cl = yy_raw;
    dy     = yy_cl - $signed({3'b0, out_row_r});
    rd_slot = out_slot_r + dy[SW-1:0];
    xx_raw = $signed({3'b0, out_col_r}) + $signed({{(CW + 3 - TW){1'b0}}, tj_r})
             - $signed({{(CW + 1){1'b0}}, r_eff});
    if (xx_raw < 0) xx_cl = '0;
    else if (xx_raw > $signed({2'b0, w_eff - 11'd1})) xx_cl = $signed({2'b0, w_eff - 11'd1});
    else xx_cl = xx_raw;
    raddr  = {rd_slot, xx_cl[CW-1:0]};
    waddr  = {in_slot_r, in_col_r};
    case (ai)
      3'd0:    ca = coef0_r;
      3'd1:    ca = coef1_r;
      3'd2:    ca = coef2_r;
      3'd3:    ca = coef3_r;
      default: ca = 16'd0;
    endcase
    case (aj)
      3'd0:    cb = coef0_r;
      3'd1:    cb = coef1_r;
      3'd2:    cb = coef2_r;
      3'd3:    cb = coef3_r;
      default: cb = 16'd0;
    endcase
    tap_last = (ti_r == span) && (tj_r == span);
  end

  // line store: one write port, one registered read port
  logic [23:0] mem [gbce_pkg::MEM_DEPTH];
  always_ff @(posedge clk) begin
    if (accept && in_tuser == gbce_pkg::REQ_PUSH) mem[waddr] <= in_tdata;
    rd_data_r <= mem[raddr];
  end

  // multiply-accumulate pipeline
  always_ff @(posedge clk) begin
    s1_wt_r <= ca * cb;
    p0_r    <= s1_wt_r * rd_data_r[7:0];
    p1_r    <= s1_wt_r * rd_data_r[15:8];
    p2_r    <= s1_wt_r * rd_data_r[23:16];
    if (state_r == ST_EVAL) begin
      acc0_r <= '0;
      acc1_r <= '0;
      acc2_r <= '0;
    end else if (s2_v_r) begin
      acc0_r <= acc0_r + AW'(p0_r);
      acc1_r <= acc1_r + AW'(p1_r);
      acc2_r <= acc2_r + AW'(p2_r);
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_EVAL;
      ST_EVAL: state_nxt = emit_ok ? ST_RUN : ST_IDLE;
      ST_RUN:  if (!issue_r && !s1_v_r && !s2_v_r) state_nxt = ST_FIN;
      ST_FIN:  if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  logic [CW:0] in_col_inc, out_col_inc;
  logic [RW:0] in_row_inc, out_row_inc;
  logic        fin_go;
  assign in_col_inc  = {1'b0, in_col_r} + 1'b1;
  assign in_row_inc  = {1'b0, in_row_r} + 1'b1;
  assign out_col_inc = {1'b0, out_col_r} + 1'b1;
  assign out_row_inc = {1'b0, out_row_r} + 1'b1;
  assign fin_go      = (state_r == ST_FIN) && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      req_r       <= gbce_pkg::REQ_PUSH;
      in_col_r    <= '0;
      in_row_r    <= '0;
      in_slot_r   <= '0;
      out_col_r   <= '0;
      out_row_r   <= '0;
      out_slot_r  <= '0;
      pending_r   <= '0;
      ti_r        <= '0;
      tj_r        <= '0;
      issue_r     <= 1'b0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      s1_v_r  <= issue_r;
      s2_v_r  <= s1_v_r;
      if (out_valid_r && out_tready && !fin_go) out_valid_r <= 1'b0;
      if (accept) begin
        req_r <= in_tuser;
        if (in_tuser == gbce_pkg::REQ_PUSH) begin
          pending_r <= pending_r + 12'd1;
          if (in_col_inc >= w_eff) begin
            in_col_r  <= '0;
            in_slot_r <= in_slot_r + 1'b1;
            in_row_r  <= (in_row_inc >= h_eff) ? '0 : in_row_inc[RW-1:0];
          end else begin
            in_col_r <= in_col_inc[CW-1:0];
          end
        end
      end
      if (state_r == ST_EVAL && emit_ok) begin
        issue_r <= 1'b1;
        ti_r    <= '0;
        tj_r    <= '0;
      end else if (issue_r) begin
        if (tap_last) issue_r <= 1'b0;
        if (tj_r == span) begin
          tj_r <= '0;
          ti_r <= ti_r + 1'b1;
        end else begin
          tj_r <= tj_r + 1'b1;
        end
      end
      if (fin_go) begin
        out_valid_r <= 1'b1;
        pending_r   <= pending_r - 12'd1;
        if (out_col_inc >= w_eff) begin
          out_col_r  <= '0;
          out_slot_r <= out_slot_r + 1'b1;
          out_row_r  <= (out_row_inc >= h_eff) ? '0 : out_row_inc[RW-1:0];
        end else begin
          out_col_r <= out_col_inc[CW-1:0];
        end
      end
    end
  end

  // saturate and load the output register
  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_data_r[7:0]   <= (|acc0_r[AW-1:40]) ? 8'hFF : acc0_r[39:32];
      out_data_r[15:8]  <= (|acc1_r[AW-1:40]) ? 8'hFF : acc1_r[39:32];
      out_data_r[23:16] <= (|acc2_r[AW-1:40]) ? 8'hFF : acc2_r[39:32];
      out_last_r        <= (out_row_inc >= 13'(h_eff)) && (out_col_inc >= w_eff);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
endmodule
`default_nettype wire

// ===== design/gbce_checker.sv =====
// Port-level checker for the blur top level, with its bind.
`timescale 1ns / 1ps
`default_nettype none
module gbce_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata,
  input wire logic        out_tlast
);
  // output register is empty after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result shown straight after reset");

  // one beat at a time: the input side closes after each accepted beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input open in the cycle after an accepted beat");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tlast)))
    else $error("stalled result changed");
endmodule

bind gaussian_blur_clamp_edge_top gbce_checker u_gbce_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
`default_nettype wire

// ===== test/tb_gaussian_blur_clamp_edge_top.sv =====
// Testbench for the clamped-edge Gaussian blur: random BGR frames checked against a predictor.
`timescale 1ns / 1ps
`default_nettype none

typedef struct packed {
  logic        frame_end;
  logic [23:0] bgr;
} blur_pix_t;

class blur_scoreboard;
  int unsigned rad, coef[4], fw, fh;
  logic [23:0] rows[gbce_pkg::MEM_DEPTH];
  int unsigned in_col, in_row, out_col, out_row, in_slot, out_slot, pend;
  blur_pix_t   blurred_q[$];
  int          errors;
  int          seen;

  function new();
    rad = 1; coef[0] = 32768; coef[1] = 16384; coef[2] = 0; coef[3] = 0;
    fw = 1024; fh = 768;
    foreach (rows[k]) rows[k] = '0;
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    in_slot = 0; out_slot = 0; pend = 0; errors = 0; seen = 0;
  endfunction

  function void set_reg(logic [2:0] idx, int unsigned val);
    case (idx)
      gbce_pkg::REG_RADIUS: rad = val & 3;
      gbce_pkg::REG_COEF0:  coef[0] = val & 16'hffff;
      gbce_pkg::REG_COEF1:  coef[1] = val & 16'hffff;
      gbce_pkg::REG_COEF2:  coef[2] = val & 16'hffff;
      gbce_pkg::REG_COEF3:  coef[3] = val & 16'hffff;
      gbce_pkg::REG_WIDTH:  fw = val & 11'h7ff;
      gbce_pkg::REG_HEIGHT: fh = val & 13'h1fff;
      default: ;
    endcase
  endfunction

  function int unsigned eff_w();
    return (fw < 1) ? 1 : (fw > gbce_pkg::MAX_WIDTH) ? gbce_pkg::MAX_WIDTH : fw;
  endfunction

  function int unsigned eff_h();
    return (fh < 1) ? 1 : (fh > gbce_pkg::ROWS_MAX) ? gbce_pkg::ROWS_MAX : fh;
  endfunction

  function int unsigned eff_r();
    return (rad > gbce_pkg::MAX_RADIUS) ? gbce_pkg::MAX_RADIUS : rad;
  endfunction

  function void blur_one();
    longint unsigned acc[3];
    longint unsigned wt, sh;
    int w, h, r, yy, xx, slot;
    blur_pix_t p;
    w = eff_w(); h = eff_h(); r = eff_r();
    acc[0] = 0; acc[1] = 0; acc[2] = 0;
    for (int i = -r; i <= r; i++) begin
      yy = int'(out_row) + i;
      if (yy < 0) yy = 0;
      if (yy > h - 1) yy = h - 1;
      slot = (int'(out_slot) + gbce_pkg::SLOT_ROWS * 8192 + (yy - int'(out_row)))
             % gbce_pkg::SLOT_ROWS;
      for (int j = -r; j <= r; j++) begin
        xx = int'(out_col) + j;
        if (xx < 0) xx = 0;
        if (xx > w - 1) xx = w - 1;
        wt = longint'(coef[i < 0 ? -i : i]) * longint'(coef[j < 0 ? -j : j]);
        for (int ch = 0; ch < 3; ch++)
          acc[ch] += wt * rows[slot * gbce_pkg::MAX_WIDTH + xx][8*ch +: 8];
      end
    end
    for (int ch = 0; ch < 3; ch++) begin
      sh = acc[ch] >> 32;
      p.bgr[8*ch +: 8] = (sh > 255) ? 8'hff : sh[7:0];
    end
    p.frame_end = (out_row + 1 >= h) && (out_col + 1 >= w);
    blurred_q.push_back(p);
    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      out_row++;
      out_slot = (out_slot + 1) % gbce_pkg::SLOT_ROWS;
      if (out_row >= h) out_row = 0;
    end
    pend--;
  endfunction

  // called for every accepted input beat
  function void note_input(logic req, logic [23:0] bgr);
    int unsigned w, h, lag;
    longint unsigned total, idx, left;
    w = eff_w(); h = eff_h(); lag = eff_r() * w + eff_r();
    if (req == gbce_pkg::REQ_PUSH) begin
      if (in_col < gbce_pkg::MAX_WIDTH) rows[in_slot * gbce_pkg::MAX_WIDTH + in_col] = bgr;
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
        in_slot = (in_slot + 1) % gbce_pkg::SLOT_ROWS;
        if (in_row >= h) in_row = 0;
      end
      pend++;
      if (pend > lag) blur_one();
    end else begin
      total = longint'(h) * w;
      idx = longint'(out_row) * w + out_col;
      left = (idx < total) ? total - idx : 1;
      if (pend > 0 && (pend > lag || longint'(pend) >= left)) blur_one();
    end
  endfunction

  function void check(logic [23:0] bgr, logic last);
    blur_pix_t e;
    seen++;
    if (blurred_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected beat: bgr %h last %b", bgr, last);
      return;
    end
    e = blurred_q.pop_front();
    if (e.bgr !== bgr || e.frame_end !== last) begin
      errors++;
      if (errors <= 10)
        $display("beat %0d: expected bgr %h last %b, got bgr %h last %b",
                 seen, e.bgr, e.frame_end, bgr, last);
    end
  endfunction
endclass

module tb_gaussian_blur_clamp_edge_top;
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [15:0] cfg_wdata = '0;

  blur_scoreboard sb = new();
  bit quiet = 1'b0;
  bit hold = 1'b0;
  int sent = 0;

  gaussian_blur_clamp_edge_top uut (.*);

  always #6 clk = ~clk;

  initial begin
    #50_000_000;
    $display("Mismatches found");
    $finish;
  end

  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready) sb.check(out_tdata, out_tlast);

  // receiver: random stall bursts, one long hold-off once traffic is flowing
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (hold || !rst_n) out_tready = 1'b0;
      else if (quiet) out_tready = 1'b1;
      else if (stall > 0) begin
        stall--;
        out_tready = 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        stall = $urandom_range(0, 13);
        out_tready = 1'b0;
      end else out_tready = 1'b1;
    end
  end

  initial begin
    wait (sb.seen >= 40);
    hold = 1'b1;
    repeat (400) @(negedge clk);
    hold = 1'b0;
  end

  task automatic send_beat(logic req, logic [23:0] bgr);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 9) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = req;
    in_tdata = bgr;
    do @(posedge clk); while (!in_tready);
    sb.note_input(req, bgr);
    sent++;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic write_reg(logic [2:0] idx, int unsigned val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_addr = idx;
    cfg_wdata = val[15:0];
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // drained frames may still be computing after the last beat: allow a full window
  task automatic settle();
    wait (sb.blurred_q.size() == 0);
    repeat (80) @(posedge clk);
  endtask

  task automatic setup(int unsigned r, int unsigned c0, int unsigned c1, int unsigned c2,
                       int unsigned c3, int unsigned w, int unsigned h);
    settle();
    write_reg(gbce_pkg::REG_RADIUS, r);
    write_reg(gbce_pkg::REG_COEF0, c0);
    write_reg(gbce_pkg::REG_COEF1, c1);
    write_reg(gbce_pkg::REG_COEF2, c2);
    write_reg(gbce_pkg::REG_COEF3, c3);
    write_reg(gbce_pkg::REG_WIDTH, w);
    write_reg(gbce_pkg::REG_HEIGHT, h);
  endtask

  function automatic logic [23:0] rand_bgr();
    case ($urandom_range(0, 5))
      0: return 24'h000000;
      1: return 24'hffffff;
      default: return 24'($urandom);
    endcase
  endfunction

  // whole frames with stray drains mixed in, then flush what is left
  task automatic run_frames(int nframes, int noise, bit fixed, logic [23:0] bgr);
    int n;
    n = nframes * sb.eff_w() * sb.eff_h();
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < noise) send_beat(gbce_pkg::REQ_DRAIN, 24'($urandom));
      send_beat(gbce_pkg::REQ_PUSH, fixed ? bgr : rand_bgr());
    end
    while (sb.pend > 0) send_beat(gbce_pkg::REQ_DRAIN, 24'($urandom));
    repeat ($urandom_range(1, 2)) send_beat(gbce_pkg::REQ_DRAIN, 24'($urandom));
  endtask

  initial begin
    int unsigned w, h;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: defaults on a tiny frame, extremes of pixel values
    setup(1, 32768, 16384, 0, 0, 4, 3);
    send_beat(gbce_pkg::REQ_DRAIN, 24'h0);
    run_frames(1, 20, 0, 0);
    // all weights full scale: every channel saturates
    setup(1, 65535, 65535, 65535, 65535, 3, 2);
    run_frames(1, 0, 1, 24'hffffff);
    // zero width and height act as one pixel
    setup(0, 65535, 0, 0, 0, 0, 0);
    run_frames(3, 30, 0, 0);
    setup(3, 9000, 8000, 7000, 6000, 2, 2);
    run_frames(2, 10, 0, 0);
    // width beyond the line store acts as a full line
    setup(0, 65535, 3000, 2000, 65535, 2047, 1);
    run_frames(1, 1, 0, 0);

    // random settings; pause until everything is out before each change
    while (sent < 1400) begin
      if (sent > 1150) quiet = 1'b1;
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 12);
      h = $urandom_range(0, 8);
      setup($urandom_range(0, 3),
            $urandom_range(0, 3) == 0 ? 65535 : $urandom_range(0, 65535),
            $urandom_range(0, 65535), $urandom_range(0, 40000),
            $urandom_range(0, 4) == 0 ? 0 : $urandom_range(0, 30000), w, h);
      run_frames($urandom_range(1, 3), 8, 0, 0);
    end

    settle();
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.blurred_q.size() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
`default_nettype wire

// ===== sim.f =====
design/gbce_pkg.sv
design/gaussian_blur_clamp_edge_top.sv
design/gbce_checker.sv
test/tb_gaussian_blur_clamp_edge_top.sv
